// ----- rtl/core/kmat_pkg.sv -----
// ----------------------------------------------------------------------------
// kmat_pkg
// types and constants shared by the keymap to ansi translator modules
// ----------------------------------------------------------------------------
package kmat_pkg;

	localparam int NUM_SPECIAL = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int MAP_ADDR_W  = 9;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_CONSOLE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CODE_FIRST = 3'd1;

	// modifier bits
	localparam int MOD_SHIFT = 0;
	localparam int MOD_CTRL  = 1;
	localparam int MOD_CAPS  = 2;

	localparam logic [7:0] ESC_CHAR   = 8'h1B;
	localparam logic [7:0] LBRACKET   = 8'h5B;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam logic [7:0] CODE_RESET = 8'd128;

	// control key translations
	localparam logic [7:0] KEY_D   = 8'h64;
	localparam logic [7:0] KEY_C   = 8'h63;
	localparam logic [7:0] KEY_W   = 8'h77;
	localparam logic [7:0] KEY_Z   = 8'h7A;
	localparam logic [7:0] CTRL_D  = 8'd4;
	localparam logic [7:0] CTRL_C  = 8'd3;
	localparam logic [7:0] CTRL_W  = 8'd23;
	localparam logic [7:0] CTRL_Z  = 8'd26;

	// final characters of the escape sequences: up, down, right, left, home, end
	localparam logic [7:0] SEQ_TAIL [NUM_SPECIAL] =
		'{8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h46};
	// home and end carry a second bracket
	localparam logic [NUM_SPECIAL-1:0] SEQ_LONG = 6'b110000;

	typedef struct packed {
		logic       command;
		logic [7:0] key_code;
		logic [2:0] modifiers;
		logic       map_select;
		logic [7:0] map_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic                        console_attached;
		logic [NUM_SPECIAL-1:0][7:0] code;
	} cfg_t;

	// one classified key event waiting for the emitter
	typedef struct packed {
		logic       esc;
		logic       long_seq;
		logic [7:0] ch;
	} seq_t;

endpackage

// ----- rtl/core/kmat_front.sv -----
// ----------------------------------------------------------------------------
// kmat_front
// keymap memory, lookup stage and classification of key events
// ----------------------------------------------------------------------------
module kmat_front import kmat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  cfg_t     cfg,
	output logic     push,
	output seq_t     push_item,
	input  logic     q_full
);

	localparam logic [7:0] KEY_A_LO = 8'h61;

	logic [7:0]            keymap_q [2**MAP_ADDR_W];
	logic [7:0]            rd_data_s1;
	logic [2:0]            mods_s1;
	logic                  valid_s1;
	logic                  accept;
	logic                  leave;
	logic                  rd_en;
	logic [MAP_ADDR_W-1:0] addr;
	logic                  hit;
	logic [NUM_SPECIAL-1:0] match;
	logic [7:0]            c;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign leave    = valid_s1 && !q_full;
	assign rd_en    = accept && !in_item.command;

	always_comb begin
		if (in_item.command) begin
			addr = {in_item.map_select, in_item.key_code};
		end else begin
			addr = {in_item.modifiers[MOD_SHIFT] && !in_item.modifiers[MOD_CTRL],
				in_item.key_code};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.command) begin
			keymap_q[addr] <= in_item.map_value;
		end
		if (rd_en) begin
			rd_data_s1 <= keymap_q[addr];
			mods_s1    <= in_item.modifiers;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (leave) begin
			valid_s1 <= 1'b0;
		end
	end

	// classification of the looked-up byte
	always_comb begin
		c         = rd_data_s1;
		hit       = 1'b0;
		push_item = '0;
		for (int i = 0; i < NUM_SPECIAL; i++) begin
			match[i] = (cfg.code[i] == c);
		end
		if (mods_s1[MOD_CTRL]) begin
			push_item.esc = 1'b0;
			hit           = 1'b1;
			case (c)
				KEY_D:   push_item.ch = CTRL_D;
				KEY_C:   push_item.ch = CTRL_C;
				KEY_W:   push_item.ch = CTRL_W;
				KEY_Z:   push_item.ch = CTRL_Z;
				default: hit = 1'b0;
			endcase
		end else if (c != 8'd0 && c <= ASCII_MAX) begin
			hit          = 1'b1;
			push_item.ch = c;
			if (mods_s1[MOD_CAPS] && (((c | CASE_BIT) >= KEY_A_LO) &&
				((c | CASE_BIT) <= KEY_Z))) begin
				push_item.ch = c ^ CASE_BIT;
			end
		end else begin
			// first matching code wins
			for (int i = NUM_SPECIAL - 1; i >= 0; i--) begin
				if (match[i]) begin
					hit                = 1'b1;
					push_item.esc      = 1'b1;
					push_item.long_seq = SEQ_LONG[i];
					push_item.ch       = SEQ_TAIL[i];
				end
			end
		end
	end

	assign push = leave && hit && cfg.console_attached;

endmodule

// ----- rtl/core/kmat_queue.sv -----
// ----------------------------------------------------------------------------
// kmat_queue
// small fifo of classified key events between lookup and emitter
// ----------------------------------------------------------------------------
module kmat_queue import kmat_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  seq_t push_item,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output seq_t q_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	seq_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign q_valid = (count_q != '0);
	assign q_item  = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/kmat_back.sv -----
// ----------------------------------------------------------------------------
// kmat_back
// emitter: spells out each queued key event, while the output does not stall, one character per cycle
// ----------------------------------------------------------------------------
module kmat_back import kmat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  seq_t      q_item,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	seq_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] pos_q;
	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       advance;
	out_item_t  next_out;

	assign advance = cur_valid_q && (!out_valid_q || !out_stall);
	assign pop     = q_valid && (!cur_valid_q || (advance && next_out.last));

	always_comb begin
		next_out.char_out = cur_q.ch;
		next_out.last     = 1'b1;
		if (cur_q.esc) begin
			case (pos_q)
				2'd0: begin
					next_out.char_out = ESC_CHAR;
					next_out.last     = 1'b0;
				end
				2'd1: begin
					next_out.char_out = LBRACKET;
					next_out.last     = 1'b0;
				end
				2'd2: begin
					next_out.char_out = cur_q.long_seq ? LBRACKET : cur_q.ch;
					next_out.last     = !cur_q.long_seq;
				end
				default: begin
					next_out.char_out = cur_q.ch;
					next_out.last     = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		if (advance) begin
			out_item_q <= next_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (advance) begin
				if (next_out.last) begin
					cur_valid_q <= 1'b0;
				end
				pos_q <= pos_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- rtl/core/keymap_to_ansi_translator_top.sv -----
// ----------------------------------------------------------------------------
// keymap_to_ansi_translator_top
// key events to terminal characters through two loadable keymaps
// ----------------------------------------------------------------------------
// path: an accepted key event passes the keymap read register, the queue, the current
//   event register and the output register before its first character goes out
// throughput: one item per cycle at the input and one character per cycle at the
//   output while neither side stalls; a key event gives up to 4 characters, spelled by the emitter
// reset: control state and configuration clear at once; keymap contents are
//   undefined until loaded, and no clearing pass is run
module keymap_to_ansi_translator_top import kmat_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items: key events and keymap loads
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_item,
	// output items: characters
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_item,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	cfg_t cfg_q;
	logic push;
	seq_t push_item;
	logic q_full;
	logic q_valid;
	seq_t q_item;
	logic pop;

	// configuration registers, always ready; indexes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.console_attached <= 1'b0;
			for (int i = 0; i < NUM_SPECIAL; i++) begin
				cfg_q.code[i] <= CODE_RESET + 8'(i);
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_CONSOLE) begin
				cfg_q.console_attached <= cfg_data[0];
			end
			for (int i = 0; i < NUM_SPECIAL; i++) begin
				if (cfg_index == CFG_CODE_FIRST + CFG_INDEX_W'(i)) begin
					cfg_q.code[i] <= cfg_data;
				end
			end
		end
	end

	// front: loads, lookup and classification
	kmat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	// decoupling queue between lookup and emitter
	kmat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// back: escape sequence emitter with output register
	kmat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/core/kmat_checker.sv -----
// ----------------------------------------------------------------------------
// kmat_checker
// port-level checks of the keymap to ansi translator
// ----------------------------------------------------------------------------
module kmat_checker import kmat_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// no output during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a stalled output item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	// only escape and bracket characters can be followed by more of an item
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |->
		(out_item.char_out == ESC_CHAR) || (out_item.char_out == LBRACKET))
		else $error("non-final character is not part of an escape prefix");

	// an escape that opens a sequence is followed by a bracket
	a_esc_then_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last &&
		(out_item.char_out == ESC_CHAR) ##1 out_valid |->
		out_item.char_out == LBRACKET)
		else $error("escape not followed by bracket");

endmodule

bind keymap_to_ansi_translator_top kmat_checker u_kmat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ----- bench/keymap_to_ansi_translator_top_tb.sv -----
// ----------------------------------------------------------------------------
// keymap_to_ansi_translator_top_tb
// self-checking bench for the keymap to ansi translator
// ----------------------------------------------------------------------------
// Keymap loads and key events go in through the input channel. A behavioral
// model of the two keymaps and the register set predicts every character. A
// monitor compares each character and its last flag in order. Directed items
// cover console gating, caps lock, control keys and the escape sequences.
// Random traffic then runs under three register settings and three idle
// patterns; before it, the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module keymap_to_ansi_translator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmat_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int REPORT_MAX    = 10;
	localparam int HOLD_CYCLES   = 150;
	localparam int RANDOM_ITEMS  = 90;
	localparam int MAX_GAP       = 16;

	// modifier patterns
	localparam logic [2:0] NO_MODS    = 3'b000;
	localparam logic [2:0] SHIFT_HELD = 3'(1 << MOD_SHIFT);
	localparam logic [2:0] CTRL_HELD  = 3'(1 << MOD_CTRL);
	localparam logic [2:0] CAPS_ON    = 3'(1 << MOD_CAPS);

	// terminal bytes
	localparam logic [7:0] ANSI_ESC     = 8'h1B;
	localparam logic [7:0] ANSI_BRACKET = "[";
	localparam logic [7:0] ASCII_DEL    = 8'h7F;
	localparam logic [7:0] LETTER_CASE  = 8'h20;
	localparam logic [7:0] CTRL_EOT     = 8'd4;
	localparam logic [7:0] CTRL_ETX     = 8'd3;
	localparam logic [7:0] CTRL_ETB     = 8'd23;
	localparam logic [7:0] CTRL_SUB     = 8'd26;
	localparam logic [7:0] CTRL_LETTERS [4] = '{"d", "c", "w", "z"};

	// final byte per special key: up, down, right, left, home, end
	localparam logic [7:0] SEQ_FINAL [NUM_SPECIAL] = '{"A", "B", "C", "D", "H", "F"};
	// home and end carry a doubled bracket
	localparam int FIRST_LONG_SEQ = 4;

	logic       clk      = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_item  = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// handshakes as seen at the falling edge before the next rising edge
	bit in_fire  = 1'b0;
	bit cfg_fire = 1'b0;

	// predicted state of the block
	logic [7:0] keymap_mem [2 * 256];
	logic       console_on;
	logic [7:0] special_codes [NUM_SPECIAL];
	out_item_t  expected_chars [$];
	out_item_t  oldest_char;

	// which entries a load has already been sent to
	bit         loaded [2][256];
	logic [7:0] plain_keys [$];
	logic [7:0] shifted_keys [$];

	// register values for the next programming pass, index 0 is the console
	logic [7:0] reg_plan [NUM_SPECIAL + 1];

	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int hold_req     = 0;
	int hold_left    = 0;

	int cycle_count   = 0;
	int fault_count   = 0;
	int items_sent    = 0;
	int events_sent   = 0;
	int chars_checked = 0;

	keymap_to_ansi_translator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic void push_char(input logic [7:0] ch, input logic fin);
		out_item_t o;
		o.char_out = ch;
		o.last     = fin;
		expected_chars.push_back(o);
	endfunction

	function automatic void predict_chars(input in_item_t it);
		logic [7:0] c;
		bit         hit;
		hit = 1'b0;
		if (it.command) begin
			keymap_mem[{it.map_select, it.key_code}] = it.map_value;
		end else if (console_on) begin
			if (it.modifiers[MOD_CTRL]) begin
				// control always reads the plain map, shift and caps do nothing
				c = keymap_mem[{1'b0, it.key_code}];
				case (c)
					"d": push_char(CTRL_EOT, 1'b1);
					"c": push_char(CTRL_ETX, 1'b1);
					"w": push_char(CTRL_ETB, 1'b1);
					"z": push_char(CTRL_SUB, 1'b1);
					default: ;
				endcase
			end else begin
				c = keymap_mem[{it.modifiers[MOD_SHIFT], it.key_code}];
				if (c != 8'd0 && c <= ASCII_DEL) begin
					if (it.modifiers[MOD_CAPS] &&
					    ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
						c = c ^ LETTER_CASE;
					push_char(c, 1'b1);
				end else begin
					// first matching special code wins when codes collide
					for (int i = 0; i < NUM_SPECIAL; i++) begin
						if (!hit && special_codes[i] == c) begin
							hit = 1'b1;
							push_char(ANSI_ESC, 1'b0);
							push_char(ANSI_BRACKET, 1'b0);
							if (i >= FIRST_LONG_SEQ)
								push_char(ANSI_BRACKET, 1'b0);
							push_char(SEQ_FINAL[i], 1'b1);
						end
					end
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// monitor: check characters, predict accepted items, track register writes
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		in_fire  = arst_n && in_valid && !in_stall;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected character %h last %b at cycle %0d",
						out_item.char_out, out_item.last, cycle_count);
			end else begin
				oldest_char = expected_chars.pop_front();
				chars_checked++;
				if (out_item.char_out !== oldest_char.char_out ||
				    out_item.last !== oldest_char.last) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("mismatch at cycle %0d: expected %h last %b, got %h last %b",
							cycle_count, oldest_char.char_out, oldest_char.last,
							out_item.char_out, out_item.last);
				end
			end
		end
		if (in_fire)
			predict_chars(in_item);
		if (cfg_fire) begin
			if (cfg_index == CFG_CONSOLE)
				console_on = cfg_data[0];
			else if (cfg_index >= CFG_CODE_FIRST &&
			         int'(cfg_index) < int'(CFG_CODE_FIRST) + NUM_SPECIAL)
				special_codes[cfg_index - CFG_CODE_FIRST] = cfg_data;
		end
	end

	// output stall: a requested hold first, random stalls otherwise
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d characters outstanding",
				cycle_count, expected_chars.size());
			$display("[keymap_to_ansi_translator_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		if (it.command && !loaded[it.map_select][it.key_code]) begin
			loaded[it.map_select][it.key_code] = 1'b1;
			if (it.map_select)
				shifted_keys.push_back(it.key_code);
			else
				plain_keys.push_back(it.key_code);
		end
		items_sent++;
		if (!it.command)
			events_sent++;
		do @(posedge clk); while (!in_fire);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	// sender pause: every predicted character out, then the pipeline settles
	task automatic wait_for_chars();
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input int upto);
		for (int r = 0; r <= upto; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? CFG_CONSOLE : CFG_CODE_FIRST + CFG_INDEX_W'(r - 1);
			cfg_data  <= reg_plan[r];
			do @(posedge clk); while (!cfg_fire);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic plan_random_codes(input int lo, input int hi);
		reg_plan[0] = 8'h01;
		for (int i = 1; i <= NUM_SPECIAL; i++)
			reg_plan[i] = 8'($urandom_range(hi, lo));
	endtask

	task automatic set_idling(input int in_pct, input int out_pct);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
	endtask

	// ------------------------------------------------------------------------
	// item builders, ignored fields are random
	// ------------------------------------------------------------------------
	function automatic in_item_t map_load(input logic sel, input logic [7:0] key,
		input logic [7:0] value);
		in_item_t it;
		it.command    = 1'b1;
		it.key_code   = key;
		it.modifiers  = 3'($urandom_range(7));
		it.map_select = sel;
		it.map_value  = value;
		return it;
	endfunction

	function automatic in_item_t key_event(input logic [7:0] key, input logic [2:0] mods);
		in_item_t it;
		it.command    = 1'b0;
		it.key_code   = key;
		it.modifiers  = mods;
		it.map_select = 1'($urandom_range(1));
		it.map_value  = 8'($urandom_range(255));
		return it;
	endfunction

	// values biased toward letters, control letters and the live special codes
	function automatic logic [7:0] random_map_value();
		case ($urandom_range(9))
			0, 1:    return 8'($urandom_range("z", "a"));
			2:       return 8'($urandom_range("Z", "A"));
			3:       return CTRL_LETTERS[$urandom_range(3)];
			4, 5:    return special_codes[$urandom_range(NUM_SPECIAL - 1)];
			6:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			7:       return 8'($urandom_range(255, 128));
			default: return 8'($urandom_range(127, 1));
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		bit       ready;
		ready = plain_keys.size() != 0 && shifted_keys.size() != 0;
		it = key_event(8'($urandom_range(255)), 3'($urandom_range(7)));
		if (!ready || $urandom_range(99) < 30) begin
			it.command   = 1'b1;
			it.map_value = random_map_value();
			// once both maps hold entries, half the loads overwrite an entry already in use
			if (ready && $urandom_range(1) == 0) begin
				if (it.map_select)
					it.key_code = shifted_keys[$urandom_range(shifted_keys.size() - 1)];
				else
					it.key_code = plain_keys[$urandom_range(plain_keys.size() - 1)];
			end
		end else if (it.modifiers[MOD_CTRL] || !it.modifiers[MOD_SHIFT]) begin
			it.key_code = plain_keys[$urandom_range(plain_keys.size() - 1)];
		end else begin
			it.key_code = shifted_keys[$urandom_range(shifted_keys.size() - 1)];
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// fill a few entries, check that a detached console drops key events
	task automatic test_console_gate();
		send_item(map_load(1'b0, 8'h00, "a"));
		send_item(map_load(1'b1, 8'hFF, "Z"));
		send_item(map_load(1'b0, 8'hFF, ASCII_DEL));
		send_item(map_load(1'b0, 8'h10, 8'd128));
		send_item(map_load(1'b0, 8'h11, 8'd133));
		send_item(map_load(1'b0, 8'h12, 8'h00));
		send_item(map_load(1'b0, 8'h13, 8'd200));
		send_item(key_event(8'h00, NO_MODS));
		release_input();
		wait_for_chars();
		reg_plan[0] = 8'h01;
		program_registers(0);
	endtask

	task automatic test_printable_keys();
		send_item(key_event(8'h00, NO_MODS));
		send_item(key_event(8'h00, CAPS_ON));
		send_item(key_event(8'hFF, SHIFT_HELD | CAPS_ON));
		// caps leaves non-letters alone
		send_item(key_event(8'hFF, CAPS_ON));
		release_input();
		wait_for_chars();
	endtask

	// special codes still at their reset values
	task automatic test_reset_specials();
		send_item(key_event(8'h10, NO_MODS));
		send_item(key_event(8'h11, CAPS_ON));
		// zero matches nothing by default
		send_item(key_event(8'h12, NO_MODS));
		release_input();
		wait_for_chars();
	endtask

	task automatic test_control_keys();
		send_item(map_load(1'b0, 8'h14, "d"));
		send_item(map_load(1'b0, 8'h15, "c"));
		send_item(map_load(1'b0, 8'h16, "w"));
		send_item(map_load(1'b0, 8'h17, "z"));
		send_item(key_event(8'h14, CTRL_HELD));
		send_item(key_event(8'h15, CTRL_HELD | SHIFT_HELD | CAPS_ON));
		send_item(key_event(8'h16, CTRL_HELD | CAPS_ON));
		send_item(key_event(8'h17, CTRL_HELD | SHIFT_HELD));
		// a control key that is none of the four emits nothing
		send_item(key_event(8'h00, CTRL_HELD));
		release_input();
		wait_for_chars();
	endtask

	// colliding codes, a code inside the printable range, and 0 / 255
	task automatic test_special_codes();
		reg_plan = '{8'h01, 8'h00, 8'hFF, 8'h00, "Z", 8'hFF, 8'd200};
		program_registers(NUM_SPECIAL);
		send_item(map_load(1'b0, 8'h18, 8'hFF));
		send_item(key_event(8'h12, NO_MODS));
		send_item(key_event(8'h18, CAPS_ON));
		send_item(key_event(8'h13, NO_MODS));
		send_item(key_event(8'hFF, SHIFT_HELD));
		send_item(key_event(8'h10, NO_MODS));
		release_input();
		wait_for_chars();
	endtask

	// hold the output long enough for the input to back up
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_req = HOLD_CYCLES;
		for (int i = 0; i < 16; i++)
			send_item(key_event((i % 2 == 0) ? 8'h12 : 8'h13,
				($urandom_range(1) != 0) ? CAPS_ON : NO_MODS));
		release_input();
		wait_for_chars();
	endtask

	task automatic test_random_traffic(input int count);
		program_registers(NUM_SPECIAL);
		for (int i = 0; i < count; i++)
			send_item(random_item());
		release_input();
		wait_for_chars();
	endtask

	initial begin
		int waited;
		arst_n <= 1'b0;
		console_on = 1'b0;
		for (int i = 0; i < NUM_SPECIAL; i++)
			special_codes[i] = 8'd128 + 8'(i);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(11, 67);
		test_console_gate();
		test_printable_keys();
		test_reset_specials();
		test_control_keys();
		test_special_codes();
		test_backpressure();

		set_idling(11, 67);
		plan_random_codes(128, 255);
		test_random_traffic(RANDOM_ITEMS);

		set_idling(67, 11);
		reg_plan = '{8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'd127, 8'd1};
		test_random_traffic(RANDOM_ITEMS);

		set_idling(0, 0);
		plan_random_codes(0, 255);
		test_random_traffic(RANDOM_ITEMS);

		waited = 0;
		while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			fault_count += expected_chars.size();
			$display("%0d expected characters never arrived", expected_chars.size());
		end

		$display("%0d items (%0d key events) sent, %0d characters checked, %0d faults",
			items_sent, events_sent, chars_checked, fault_count);
		$display("console gating, caps, control keys, colliding codes, output hold");
		if (fault_count == 0)
			$display("[keymap_to_ansi_translator_top] OK");
		else
			$display("[keymap_to_ansi_translator_top] ERROR");
		$finish;
	end

endmodule
